@@ hdl/lbt_pkg.sv @@
// ----------------------------------------------------------------------------
// lbt_pkg: shared definitions of the label backpatch table
// Field widths, result kinds, command codes and the records that travel
// along the row of table cells.
// ----------------------------------------------------------------------------
package lbt_pkg;

    // default sizes
    localparam int MAX_LABELS = 128;
    localparam int MAX_FIXUPS = 8;
    // code space size; a power of two, so the position reduction is a mask
    localparam int CODE_BYTES = 4096;

    // field widths
    localparam int KEY_W  = 64;
    localparam int POS_W  = 12;
    localparam int KIND_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PATCH      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORDED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TABLE_FULL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIXUP_FULL = 2'd3;

    // input commands
    localparam logic CMD_REFERENCE = 1'b0;
    localparam logic CMD_DEFINE    = 1'b1;

    // search record handed from cell to cell (entry index and count travel beside it)
    typedef struct packed {
        logic             found;
        logic             defined;
        logic [POS_W-1:0] pos;
    } probe_t;

    // entry update broadcast to all cells (index and count travel beside it)
    typedef struct packed {
        logic             en;
        logic             defined;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
    } cell_wr_t;

endpackage

@@ hdl/lbt_ram.sv @@
// ----------------------------------------------------------------------------
// lbt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module lbt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lbt_cell.sv @@
// ----------------------------------------------------------------------------
// lbt_cell: one entry of the label table
// Holds key, defined flag, position and fixup count of one label, compares
// its key against the query and passes the search record to its neighbor.
// ----------------------------------------------------------------------------
module lbt_cell #(
    parameter int MAX_LABELS = lbt_pkg::MAX_LABELS,
    parameter int MAX_FIXUPS = lbt_pkg::MAX_FIXUPS,
    parameter int CELL_ID    = 0
) (
    input  logic                                aclk,
    // query and table fill
    input  logic [lbt_pkg::KEY_W-1:0]           query_key,
    input  logic [$clog2(MAX_LABELS+1)-1:0]     entry_count,
    // entry update
    input  lbt_pkg::cell_wr_t                   wr,
    input  logic [$clog2(MAX_LABELS)-1:0]       wr_idx,
    input  logic [$clog2(MAX_FIXUPS+1)-1:0]     wr_cnt,
    // search record from the previous cell
    input  lbt_pkg::probe_t                     prb_in,
    input  logic [$clog2(MAX_LABELS)-1:0]       prb_idx_in,
    input  logic [$clog2(MAX_FIXUPS+1)-1:0]     prb_cnt_in,
    // search record to the next cell
    output lbt_pkg::probe_t                     prb_out,
    output logic [$clog2(MAX_LABELS)-1:0]       prb_idx_out,
    output logic [$clog2(MAX_FIXUPS+1)-1:0]     prb_cnt_out
);

    localparam int IW = $clog2(MAX_LABELS);
    localparam int CW = $clog2(MAX_FIXUPS+1);
    localparam int EW = $clog2(MAX_LABELS+1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);
    localparam logic [EW-1:0] MY_NUM = EW'(CELL_ID);

    logic [lbt_pkg::KEY_W-1:0] key_reg;
    logic                      def_reg;
    logic [lbt_pkg::POS_W-1:0] pos_reg;
    logic [CW-1:0]             cnt_reg;

    lbt_pkg::probe_t           prb_reg;
    logic [IW-1:0]             prb_idx_reg;
    logic [CW-1:0]             prb_cnt_reg;

    logic in_use;
    logic hit;

    // only entries below the fill count take part in the search
    assign in_use = (MY_NUM < entry_count);
    assign hit    = in_use && (key_reg == query_key) && !prb_in.found;

    // update the entry when addressed
    always_ff @(posedge aclk) begin
        if (wr.en && (wr_idx == MY_IDX)) begin
            key_reg <= wr.key;
            def_reg <= wr.defined;
            pos_reg <= wr.pos;
            cnt_reg <= wr_cnt;
        end
    end

    // pick up this entry on a match, else pass the record along
    always_ff @(posedge aclk) begin
        if (hit) begin
            prb_reg.found   <= 1'b1;
            prb_reg.defined <= def_reg;
            prb_reg.pos     <= pos_reg;
            prb_idx_reg     <= MY_IDX;
            prb_cnt_reg     <= cnt_reg;
        end else begin
            prb_reg         <= prb_in;
            prb_idx_reg     <= prb_idx_in;
            prb_cnt_reg     <= prb_cnt_in;
        end
    end

    assign prb_out     = prb_reg;
    assign prb_idx_out = prb_idx_reg;
    assign prb_cnt_out = prb_cnt_reg;

endmodule

@@ hdl/label_backpatch_table.sv @@
// ----------------------------------------------------------------------------
// label_backpatch_table: label table with forward-reference backpatching
// Takes label references and definitions, keeps each label's position and
// pending fixups, and emits patch words (address, value) for the code image.
// ----------------------------------------------------------------------------
// One item is handled at a time. The label key is looked up by a search record
// that walks the row of MAX_LABELS cells one cell per cycle, so every item is
// accepted, searched through the row, decided, and then handed to the output
// register once it is free. A definition that finds n stored fixups emits n
// patch words, each read from the fixup RAM and then emitted once the output
// register is free. The table needs no clearing pass after reset: entries
// beyond the fill count never match and fixups beyond an entry's count are
// never read. A full table or a full fixup list is reported by one word of
// kind 2 or 3 and leaves the table unchanged. The last word of every item
// carries tlast.
// ----------------------------------------------------------------------------
module label_backpatch_table #(
    parameter int MAX_LABELS = lbt_pkg::MAX_LABELS,
    parameter int MAX_FIXUPS = lbt_pkg::MAX_FIXUPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] label_key, [75:64] position, [79:76] zero
    input  logic        s_tuser,   // [0] cmd
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] patch_address, [23:12] patch_value
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);

    localparam int IW    = $clog2(MAX_LABELS);
    localparam int CW    = $clog2(MAX_FIXUPS+1);
    localparam int EW    = $clog2(MAX_LABELS+1);
    localparam int FW    = (MAX_FIXUPS > 1) ? $clog2(MAX_FIXUPS) : 1;
    localparam int FX_DEPTH = MAX_LABELS * (1 << FW);
    localparam int POS_W = lbt_pkg::POS_W;
    localparam int KEY_W = lbt_pkg::KEY_W;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEARCH   = 6'b000010,
        ST_DECIDE   = 6'b000100,
        ST_RESP     = 6'b001000,
        ST_PATCH_RD = 6'b010000,
        ST_PATCH_WR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // query
    logic                    cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [IW-1:0]           scan_reg, scan_next;
    logic [EW-1:0]           entry_count_reg, entry_count_next;
    // patch loop
    logic [IW-1:0]           e_reg, e_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [FW-1:0]           j_reg, j_next;
    // pending single result
    logic [lbt_pkg::KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [POS_W-1:0]        res_addr_reg, res_addr_next;
    logic [POS_W-1:0]        res_val_reg, res_val_next;
    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [lbt_pkg::KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [POS_W-1:0]        m_addr_reg, m_addr_next;
    logic [POS_W-1:0]        m_val_reg, m_val_next;
    logic                    m_last_reg, m_last_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    patch_last;

    // cell row
    lbt_pkg::probe_t         prb     [0:MAX_LABELS];
    logic [IW-1:0]           prb_idx [0:MAX_LABELS];
    logic [CW-1:0]           prb_cnt [0:MAX_LABELS];
    lbt_pkg::cell_wr_t       cell_wr;
    logic [IW-1:0]           cell_wr_idx;
    logic [CW-1:0]           cell_wr_cnt;
    lbt_pkg::probe_t         tail;
    logic [IW-1:0]           tail_idx;
    logic [CW-1:0]           tail_cnt;

    // fixup RAM
    logic                    fx_wr_en;
    logic [IW+FW-1:0]        fx_wr_addr;
    logic                    fx_rd_en;
    logic [POS_W-1:0]        fx_rd_data;

    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign tail       = prb[MAX_LABELS];
    assign tail_idx   = prb_idx[MAX_LABELS];
    assign tail_cnt   = prb_cnt[MAX_LABELS];
    assign patch_last = (j_reg == FW'(n_reg - CW'(1)));

    // empty record enters the row
    assign prb[0]     = '0;
    assign prb_idx[0] = '0;
    assign prb_cnt[0] = '0;

    for (genvar i = 0; i < MAX_LABELS; i++) begin : g_cell
        lbt_cell #(
            .MAX_LABELS (MAX_LABELS),
            .MAX_FIXUPS (MAX_FIXUPS),
            .CELL_ID    (i)
        ) u_cell (
            .aclk        (aclk),
            .query_key   (key_reg),
            .entry_count (entry_count_reg),
            .wr          (cell_wr),
            .wr_idx      (cell_wr_idx),
            .wr_cnt      (cell_wr_cnt),
            .prb_in      (prb[i]),
            .prb_idx_in  (prb_idx[i]),
            .prb_cnt_in  (prb_cnt[i]),
            .prb_out     (prb[i+1]),
            .prb_idx_out (prb_idx[i+1]),
            .prb_cnt_out (prb_cnt[i+1])
        );
    end

    lbt_ram #(
        .WIDTH (POS_W),
        .DEPTH (FX_DEPTH)
    ) u_fixup_ram (
        .aclk    (aclk),
        .wr_en   (fx_wr_en),
        .wr_addr (fx_wr_addr),
        .wr_data (pos_reg),
        .rd_en   (fx_rd_en),
        .rd_addr ({e_reg, j_reg}),
        .rd_data (fx_rd_data)
    );

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        pos_next         = pos_reg;
        scan_next        = scan_reg;
        entry_count_next = entry_count_reg;
        e_next           = e_reg;
        n_next           = n_reg;
        j_next           = j_reg;
        res_kind_next    = res_kind_reg;
        res_addr_next    = res_addr_reg;
        res_val_next     = res_val_reg;
        m_kind_next      = m_kind_reg;
        m_addr_next      = m_addr_reg;
        m_val_next       = m_val_reg;
        m_last_next      = m_last_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;

        cell_wr.en      = 1'b0;
        cell_wr.defined = tail.defined;
        cell_wr.pos     = tail.pos;
        cell_wr.key     = key_reg;
        cell_wr_idx     = tail_idx;
        cell_wr_cnt     = tail_cnt;
        fx_wr_en        = 1'b0;
        fx_wr_addr      = {tail_idx, FW'(tail_cnt)};
        fx_rd_en        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // latch the query and start the walk
                if (in_accept) begin
                    cmd_next   = s_tuser;
                    key_next   = s_tdata[63:0];
                    pos_next   = POS_W'(32'(s_tdata[75:64]) % lbt_pkg::CODE_BYTES);
                    scan_next  = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // wait for the record to leave the last cell
                if (scan_reg == IW'(MAX_LABELS - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            ST_DECIDE: begin
                res_kind_next = lbt_pkg::KIND_RECORDED;
                res_addr_next = '0;
                res_val_next  = '0;
                state_next    = ST_RESP;
                if (!tail.found) begin
                    // unknown label: new entry unless the table is full
                    if (entry_count_reg == EW'(MAX_LABELS)) begin
                        res_kind_next = lbt_pkg::KIND_TABLE_FULL;
                    end else begin
                        cell_wr.en       = 1'b1;
                        cell_wr_idx      = IW'(entry_count_reg);
                        cell_wr.defined  = cmd_reg;
                        cell_wr.pos      = (cmd_reg == lbt_pkg::CMD_DEFINE) ? pos_reg : '0;
                        cell_wr_cnt      = (cmd_reg == lbt_pkg::CMD_DEFINE) ? '0 : CW'(1);
                        entry_count_next = entry_count_reg + EW'(1);
                        fx_wr_en         = (cmd_reg == lbt_pkg::CMD_REFERENCE);
                        fx_wr_addr       = {IW'(entry_count_reg), FW'(0)};
                    end
                end else if (cmd_reg == lbt_pkg::CMD_DEFINE) begin
                    // (re)definition: set position, then patch every fixup
                    cell_wr.en      = 1'b1;
                    cell_wr.defined = 1'b1;
                    cell_wr.pos     = pos_reg;
                    if (tail_cnt != '0) begin
                        e_next     = tail_idx;
                        n_next     = tail_cnt;
                        j_next     = '0;
                        state_next = ST_PATCH_RD;
                    end
                end else if (tail.defined) begin
                    // reference to a defined label: patch at once
                    res_kind_next = lbt_pkg::KIND_PATCH;
                    res_addr_next = pos_reg;
                    res_val_next  = tail.pos;
                end else if (tail_cnt >= CW'(MAX_FIXUPS)) begin
                    res_kind_next = lbt_pkg::KIND_FIXUP_FULL;
                end else begin
                    // append to the fixup list
                    cell_wr.en  = 1'b1;
                    cell_wr_cnt = tail_cnt + CW'(1);
                    fx_wr_en    = 1'b1;
                end
            end
            ST_RESP: begin
                // hand the single result to the output register
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_addr_next   = res_addr_reg;
                    m_val_next    = res_val_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PATCH_RD: begin
                fx_rd_en   = 1'b1;
                state_next = ST_PATCH_WR;
            end
            ST_PATCH_WR: begin
                // emit one patch word per stored fixup
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = lbt_pkg::KIND_PATCH;
                    m_addr_next   = fx_rd_data;
                    m_val_next    = pos_reg;
                    m_last_next   = patch_last;
                    if (patch_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + FW'(1);
                        state_next = ST_PATCH_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        scan_reg     <= scan_next;
        e_reg        <= e_next;
        n_reg        <= n_next;
        j_reg        <= j_next;
        res_kind_reg <= res_kind_next;
        res_addr_reg <= res_addr_next;
        res_val_reg  <= res_val_next;
        m_kind_reg   <= m_kind_next;
        m_addr_reg   <= m_addr_next;
        m_val_reg    <= m_val_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_val_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // fill count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= EW'(MAX_LABELS))
        else $error("entry count beyond table size");

    // fill count moves only in the decision cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_count_reg != $past(entry_count_reg)) |-> $past(state_reg == ST_DECIDE))
        else $error("entry count changed outside decision");

    // patch loop index stays inside the stored fixups
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PATCH_RD) |-> (CW'(j_reg) < n_reg))
        else $error("patch index beyond fixup count");

    // one item at a time: an accepted word closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input taken while an item is in work");

endmodule
